/* rtl/log_linear_latency_histogram_assert.svh */
// ---------------------------------------------------------------------------
// log_linear_latency_histogram assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef LOG_LINEAR_LATENCY_HISTOGRAM_ASSERT_SVH
`define LOG_LINEAR_LATENCY_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define LLH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LLH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/llh_pkg.sv */
// ---------------------------------------------------------------------------
// llh_pkg
// types, constants and bucket math for the log-linear latency histogram
// ---------------------------------------------------------------------------
`default_nettype none

package llh_pkg;

    localparam int NUM_OCTAVES = 24;
    localparam int SUB_BITS    = 4;
    localparam int NUM_BUCKETS = NUM_OCTAVES << SUB_BITS;
    localparam int OCT_W       = $clog2(NUM_OCTAVES);
    localparam int IDX_W       = OCT_W + SUB_BITS;

    localparam int VALUE_W = 64;
    localparam int TOTAL_W = 64;
    localparam int HALF_W  = TOTAL_W / 2;
    localparam int Q_W     = 17;
    localparam int PROD_W  = HALF_W + Q_W;
    localparam int LB_W    = 24;

    localparam logic [Q_W-1:0]   Q_ONE       = Q_W'(65536);
    localparam logic [IDX_W-1:0] LAST_BUCKET = IDX_W'(NUM_BUCKETS - 1);

    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } llh_op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_TGT,
        ST_WALK,
        ST_DONE
    } llh_state_t;

    typedef struct packed
    {
        llh_op_t                    op;
        logic signed [VALUE_W-1:0]  latency_ns;
        logic [Q_W-1:0]             quantile_fraction;
    } llh_in_t;

    typedef struct packed
    {
        logic [LB_W-1:0]    lower_bound;
        logic [TOTAL_W-1:0] total_count;
        logic               is_empty;
    } llh_out_t;

    // sample to bucket index: octave from the top set bit, sub from the bits below it
    function automatic logic [IDX_W-1:0] bucket_of(input logic signed [VALUE_W-1:0] raw);
        logic [NUM_OCTAVES-1:0] v;
        logic [NUM_OCTAVES-1:0] shifted;
        logic [OCT_W-1:0]       oct;
        logic [SUB_BITS-1:0]    sub;
        v       = '0;
        shifted = '0;
        oct     = '0;
        sub     = '0;
        if (raw[VALUE_W-1] || raw == '0)
        begin
            v = '0;
        end
        else if (raw[VALUE_W-2:NUM_OCTAVES] != '0)
        begin
            v = '1;
        end
        else
        begin
            v = raw[NUM_OCTAVES-1:0];
        end
        for (int i = 0; i < NUM_OCTAVES; i++)
        begin
            if (v[i])
            begin
                oct = OCT_W'(i);
            end
        end
        if (int'(oct) >= SUB_BITS)
        begin
            shifted = v >> (int'(oct) - SUB_BITS);
            sub     = shifted[SUB_BITS-1:0];
        end
        return {oct, sub};
    endfunction

    // lowest value that lands in a bucket, cut to the field width
    function automatic logic [LB_W-1:0] lower_bound_of(input logic [IDX_W-1:0] idx);
        logic [OCT_W-1:0]    oct;
        logic [SUB_BITS-1:0] sub;
        logic [LB_W-1:0]     v;
        oct = idx[IDX_W-1:SUB_BITS];
        sub = idx[SUB_BITS-1:0];
        v   = LB_W'(1) << oct;
        if (int'(oct) >= SUB_BITS)
        begin
            v = v | (LB_W'(sub) << (int'(oct) - SUB_BITS));
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/log_linear_latency_histogram.sv */
// ---------------------------------------------------------------------------
// log_linear_latency_histogram
// log-linear latency histogram with record and quantile query transactions
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bucket memory, one
// bucket a cycle over all 384 buckets, and holds sample_stall high until it
// is done. A record transaction is taken every cycle while the block is idle:
// the bucket count is read from the single-port-write, registered-read
// memory, bumped and written back in the following cycle, with the last
// write forwarded when two records in a row hit the same bucket; records give
// no result. A query transaction blocks new input until its result is
// registered: ST_MUL forms two 32x17 products and ST_TGT their shifted sum as
// the target rank, then the walk reads one bucket a cycle from bucket 0 until
// the running sum reaches the target or the last bucket is read, then ST_DONE
// loads the output register once the previous result has been taken. An
// empty histogram skips the rank and the walk and answers with is_empty set.
// The finished result sits in the output register until taken, and records
// are still accepted meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

`include "log_linear_latency_histogram_assert.svh"

module log_linear_latency_histogram
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire llh_pkg::llh_in_t sample,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output llh_pkg::llh_out_t     result
);

    import llh_pkg::*;

    // bucket count store
    logic [TOTAL_W-1:0] mem [NUM_BUCKETS];
    logic [TOTAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [TOTAL_W-1:0] mem_wd;

    // control
    llh_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // record read-modify-write stage and forwarding of the last write
    logic               s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [TOTAL_W-1:0] fwd_data_reg;
    logic [TOTAL_W-1:0] rec_count;
    logic [TOTAL_W-1:0] rec_sum;

    // query datapath
    logic [Q_W-1:0]     q_reg, q_next;
    logic [PROD_W-1:0]  p_lo_reg, p_hi_reg;
    logic [TOTAL_W-1:0] target_sum;
    logic [TOTAL_W-1:0] target_reg, target_next;
    logic [TOTAL_W-1:0] running_reg, running_next;
    logic [TOTAL_W-1:0] walk_sum;
    logic [IDX_W-1:0]   walk_addr_reg, walk_addr_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [LB_W-1:0]    res_lb_reg, res_lb_next;
    logic               res_empty_reg, res_empty_next;

    // output register
    logic               result_valid_reg, result_valid_next;
    llh_out_t           result_reg, result_next;

    logic               sample_accept;
    logic [IDX_W-1:0]   sample_idx;
    logic [Q_W-1:0]     q_sat;

    assign sample_stall  = (state_reg != ST_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign sample_idx    = bucket_of(sample.latency_ns);
    assign q_sat         = (sample.quantile_fraction > Q_ONE) ? Q_ONE
                                                              : sample.quantile_fraction;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a write landing at the last edge is not yet seen by the read issued with it
    assign rec_count = (fwd_valid_reg && fwd_idx_reg == s1_idx_reg) ? fwd_data_reg
                                                                      : rd_data_reg;
    assign rec_sum   = rec_count + TOTAL_W'(1);

    // floor(total * q / 2^16) from the two half products
    assign target_sum = (TOTAL_W'(p_hi_reg) << 16) + TOTAL_W'(p_lo_reg >> 16);

    assign walk_sum = running_reg + rd_data_reg;

    // memory write port: clearing pass or record write-back
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = s1_idx_reg;
        mem_wd = rec_sum;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = '0;
        end
        else if (s1_valid_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state and datapath control
    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        total_next        = total_reg;
        s1_valid_next     = 1'b0;
        q_next            = q_reg;
        target_next       = target_reg;
        running_next      = running_reg;
        walk_addr_next    = walk_addr_reg;
        rd_idx_next       = rd_idx_reg;
        res_lb_next       = res_lb_reg;
        res_empty_next    = res_empty_reg;
        rd_addr           = walk_addr_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_BUCKET)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (sample_valid && sample.op == OP_RECORD)
                begin
                    rd_addr = sample_idx;
                end
                if (sample_accept)
                begin
                    if (sample.op == OP_RECORD)
                    begin
                        s1_valid_next = 1'b1;
                        total_next    = total_reg + TOTAL_W'(1);
                    end
                    else
                    begin
                        walk_addr_next = '0;
                        running_next   = '0;
                        q_next         = q_sat;
                        if (total_reg == '0)
                        begin
                            res_lb_next    = '0;
                            res_empty_next = 1'b1;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end

            ST_MUL:
            begin
                state_next = ST_TGT;
            end

            ST_TGT:
            begin
                // rank of at least one, first bucket read goes out now
                target_next    = (target_sum == '0) ? TOTAL_W'(1) : target_sum;
                rd_idx_next    = walk_addr_reg;
                walk_addr_next = walk_addr_reg + IDX_W'(1);
                state_next     = ST_WALK;
            end

            ST_WALK:
            begin
                if (walk_sum >= target_reg || rd_idx_reg == LAST_BUCKET)
                begin
                    res_lb_next    = lower_bound_of(rd_idx_reg);
                    res_empty_next = 1'b0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    running_next = walk_sum;
                    rd_idx_next  = walk_addr_reg;
                    if (walk_addr_reg != LAST_BUCKET)
                    begin
                        walk_addr_next = walk_addr_reg + IDX_W'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next       = 1'b1;
                    result_next.lower_bound = res_lb_reg;
                    result_next.total_count = total_reg;
                    result_next.is_empty    = res_empty_reg;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            total_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            total_reg        <= total_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_valid_reg    <= s1_valid_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= sample_idx;
        fwd_idx_reg   <= s1_idx_reg;
        fwd_data_reg  <= rec_sum;
        q_reg         <= q_next;
        p_lo_reg      <= PROD_W'(total_reg[HALF_W-1:0]) * PROD_W'(q_reg);
        p_hi_reg      <= PROD_W'(total_reg[TOTAL_W-1:HALF_W]) * PROD_W'(q_reg);
        target_reg    <= target_next;
        running_reg   <= running_next;
        walk_addr_reg <= walk_addr_next;
        rd_idx_reg    <= rd_idx_next;
        res_lb_reg    <= res_lb_next;
        res_empty_reg <= res_empty_next;
        result_reg    <= result_next;
    end

    // each record transaction adds exactly one to the total
    `LLH_ASSERT_NEXT(a_total_bump, sample_accept && sample.op == OP_RECORD,
        total_reg == $past(total_reg) + TOTAL_W'(1), "total not bumped by record")

    // a query transaction always leaves idle for its own work
    `LLH_ASSERT_NEXT(a_query_leaves_idle, sample_accept && sample.op == OP_QUERY,
        state_reg != ST_IDLE, "query did not start")

    // no bucket write may overlap the target computation or the walk
    `LLH_ASSERT_NOW(a_no_write_in_walk,
        state_reg == ST_MUL || state_reg == ST_TGT || state_reg == ST_WALK,
        !mem_we, "bucket write during query")

    // the walk never looks past the last bucket
    `LLH_ASSERT_NOW(a_walk_in_range, state_reg == ST_WALK,
        rd_idx_reg <= LAST_BUCKET && walk_addr_reg <= LAST_BUCKET, "walk out of range")

endmodule

`default_nettype wire
